// ===== rtl/mid_pkg.sv =====
// ----------------------------------------------------------------------------
// mid_pkg
// Shared types and mode codes for the multicore interrupt distributor.
// ----------------------------------------------------------------------------
package mid_pkg;

   localparam logic [2:0] MODE_SAMPLE = 3'd0;
   localparam logic [2:0] MODE_ENABLE = 3'd1;
   localparam logic [2:0] MODE_POST   = 3'd2;
   localparam logic [2:0] MODE_ACK    = 3'd3;
   localparam logic [2:0] MODE_READ   = 3'd4;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] line_levels;
      logic [7:0] enable_value;
      logic [3:0] target_cpus;
      logic [1:0] cpu_index;
      logic [7:0] soft_bits;
   } req_type;

   typedef struct packed {
      logic [3:0] raise_req;
      logic [3:0] lower_req;
      logic [3:0] wake_cpus;
      logic [7:0] masked_status;
      logic [7:0] enable_now;
      logic [7:0] soft_pending;
   } rsp_type;

endpackage

// ===== rtl/mid_in_stage.sv =====
// ----------------------------------------------------------------------------
// mid_in_stage
// Input register: holds one request word until the core takes it.
// ----------------------------------------------------------------------------
module mid_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mid_pkg::req_type req_word,
   input  logic             out_ready,
   output logic             take,
   output mid_pkg::req_type held_word
);

   logic             valid_ff;
   logic             valid_in;
   logic             load;
   mid_pkg::req_type word_ff;

   assign take      = valid_ff & out_ready;
   assign req_stall = valid_ff & ~take;
   assign load      = req_valid & ~req_stall;
   assign valid_in  = load | (valid_ff & ~take);
   assign held_word = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= req_word;
      end
   end

endmodule

// ===== rtl/mid_core.sv =====
// ----------------------------------------------------------------------------
// mid_core
// Distributor state and the single-pass update for one request word.
// ----------------------------------------------------------------------------
module mid_core #(
   parameter int NUM_LINES  = 8,
   parameter int NUM_CPUS   = 4,
   parameter int SOFT_WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [31:0]      route_map,
   input  logic             take,
   input  mid_pkg::req_type req_word,
   output mid_pkg::rsp_type rsp_word
);

   localparam int RouteW = (NUM_LINES * NUM_CPUS > 32) ? NUM_LINES * NUM_CPUS : 32;

   logic [NUM_LINES-1:0]  prev_levels_ff, prev_levels_in;
   logic [NUM_LINES-1:0]  raw_lines_ff, raw_lines_in;
   logic [NUM_LINES-1:0]  line_enable_ff, line_enable_in;
   logic [NUM_LINES-1:0]  cpu_raw_ff    [NUM_CPUS];
   logic [NUM_LINES-1:0]  cpu_raw_in    [NUM_CPUS];
   logic [NUM_LINES-1:0]  cpu_active_ff [NUM_CPUS];
   logic [NUM_LINES-1:0]  cpu_active_in [NUM_CPUS];
   logic [SOFT_WIDTH-1:0] cpu_soft_ff   [NUM_CPUS];
   logic [SOFT_WIDTH-1:0] cpu_soft_in   [NUM_CPUS];

   logic [RouteW-1:0]     route_ext;
   logic [31:0]           levels_ext, enable_ext, target_ext, soft_ext;
   logic [NUM_LINES-1:0]  levels, en_val, rise, fall;
   logic [NUM_CPUS-1:0]   targets;
   logic [SOFT_WIDTH-1:0] soft_val;
   logic [NUM_CPUS-1:0]   raise_v, lower_v, wake_v;
   logic [NUM_CPUS-1:0]   soft_busy;
   logic [31:0]           raise_ext, lower_ext, wake_ext, masked_ext, enable_now_ext;
   logic [31:0]           pend_acc;

   // unused upper field bits drop out through the zero-extend and part-select
   assign route_ext  = RouteW'(route_map);
   assign levels_ext = 32'(req_word.line_levels);
   assign enable_ext = 32'(req_word.enable_value);
   assign target_ext = 32'(req_word.target_cpus);
   assign soft_ext   = 32'(req_word.soft_bits);
   assign levels     = levels_ext[NUM_LINES-1:0];
   assign en_val     = enable_ext[NUM_LINES-1:0];
   assign targets    = target_ext[NUM_CPUS-1:0];
   assign soft_val   = soft_ext[SOFT_WIDTH-1:0];
   assign rise       = levels & ~prev_levels_ff;
   assign fall       = prev_levels_ff & ~levels;

   always_comb begin
      logic [NUM_LINES-1:0]  col, r_rise, r_fall, e_rise, e_fall, act_nxt;
      logic [NUM_LINES-1:0]  lt_mask, le_mask, hit;
      logic [SOFT_WIDTH-1:0] soft_nxt;
      logic                  up, down, soft_idle, sel;

      prev_levels_in = prev_levels_ff;
      raw_lines_in   = raw_lines_ff;
      line_enable_in = line_enable_ff;
      raise_v        = '0;
      lower_v        = '0;
      wake_v         = '0;
      soft_busy      = '0;
      pend_acc       = '0;

      unique case (req_word.mode)
         mid_pkg::MODE_SAMPLE: begin
            prev_levels_in = levels;
            raw_lines_in   = (raw_lines_ff & ~fall) | rise;
         end
         mid_pkg::MODE_ENABLE: begin
            line_enable_in = en_val;
         end
         default: begin
         end
      endcase

      for (int c = 0; c < NUM_CPUS; c++) begin
         col = '0;
         for (int i = 0; i < NUM_LINES; i++) begin
            col[i] = route_ext[i * NUM_CPUS + c];
         end
         r_rise  = rise & col;
         r_fall  = fall & col;
         e_rise  = r_rise & line_enable_ff;
         e_fall  = r_fall & line_enable_ff;
         act_nxt = (cpu_active_ff[c] & ~e_fall) | e_rise;

         // edges are taken lowest line first: line i sees lower lines already
         // applied and higher lines still at their old active bits
         up   = 1'b0;
         down = 1'b0;
         for (int i = 0; i < NUM_LINES; i++) begin
            lt_mask = NUM_LINES'((33'd1 << i) - 33'd1);
            le_mask = lt_mask | NUM_LINES'(33'd1 << i);
            if (e_rise[i] && ((act_nxt & lt_mask) == '0)
                && ((cpu_active_ff[c] & ~lt_mask) == '0)) begin
               up = 1'b1;
            end
            if (e_fall[i] && ((act_nxt & le_mask) == '0)
                && ((cpu_active_ff[c] & ~le_mask) == '0)) begin
               down = 1'b1;
            end
         end

         hit       = cpu_raw_ff[c] & en_val;
         soft_idle = (cpu_soft_ff[c] == '0);
         soft_busy[c] = ~soft_idle;
         sel       = (32'(req_word.cpu_index) == c);
         soft_nxt  = cpu_soft_ff[c];
         cpu_raw_in[c]    = cpu_raw_ff[c];
         cpu_active_in[c] = cpu_active_ff[c];

         unique case (req_word.mode)
            mid_pkg::MODE_SAMPLE: begin
               cpu_raw_in[c]    = (cpu_raw_ff[c] & ~r_fall) | r_rise;
               cpu_active_in[c] = act_nxt;
               if (soft_idle) begin
                  raise_v[c] = up;
                  wake_v[c]  = up;
                  lower_v[c] = ~up & down;
               end
            end
            mid_pkg::MODE_ENABLE: begin
               if (soft_idle) begin
                  if ((cpu_active_ff[c] == '0) && (hit != '0)) begin
                     raise_v[c] = 1'b1;
                  end else if ((cpu_active_ff[c] != '0) && (hit == '0)) begin
                     lower_v[c] = 1'b1;
                  end
               end
               cpu_active_in[c] = hit;
            end
            mid_pkg::MODE_POST: begin
               if (targets[c]) begin
                  soft_nxt = cpu_soft_ff[c] | soft_val;
                  if (cpu_active_ff[c] == '0) begin
                     raise_v[c] = 1'b1;
                     wake_v[c]  = 1'b1;
                  end
               end
            end
            mid_pkg::MODE_ACK: begin
               if (sel && !soft_idle) begin
                  soft_nxt = cpu_soft_ff[c] & ~soft_val;
                  if ((cpu_active_ff[c] == '0) && (soft_nxt == '0)) begin
                     lower_v[c] = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase

         cpu_soft_in[c] = soft_nxt;
         if (sel) begin
            pend_acc = pend_acc | 32'(soft_nxt);
         end
      end
   end

   assign raise_ext      = 32'(raise_v);
   assign lower_ext      = 32'(lower_v);
   assign wake_ext       = 32'(wake_v);
   assign masked_ext     = 32'(raw_lines_in & line_enable_in);
   assign enable_now_ext = 32'(line_enable_in);

   always_comb begin
      rsp_word.raise_req     = raise_ext[3:0];
      rsp_word.lower_req     = lower_ext[3:0];
      rsp_word.wake_cpus     = wake_ext[3:0];
      rsp_word.masked_status = masked_ext[7:0];
      rsp_word.enable_now    = enable_now_ext[7:0];
      rsp_word.soft_pending  = pend_acc[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_levels_ff <= '0;
         raw_lines_ff   <= '0;
         line_enable_ff <= '0;
         for (int c = 0; c < NUM_CPUS; c++) begin
            cpu_raw_ff[c]    <= '0;
            cpu_active_ff[c] <= '0;
            cpu_soft_ff[c]   <= '0;
         end
      end else if (take) begin
         prev_levels_ff <= prev_levels_in;
         raw_lines_ff   <= raw_lines_in;
         line_enable_ff <= line_enable_in;
         for (int c = 0; c < NUM_CPUS; c++) begin
            cpu_raw_ff[c]    <= cpu_raw_in[c];
            cpu_active_ff[c] <= cpu_active_in[c];
            cpu_soft_ff[c]   <= cpu_soft_in[c];
         end
      end
   end

   // a CPU with pending software interrupts never gets a sampled raise/lower
   sample_soft_blocks: assert property (@(posedge clock) disable iff (reset)
      (take && (req_word.mode == mid_pkg::MODE_SAMPLE))
         |-> (((raise_v | lower_v) & soft_busy) == '0))
      else $error("sample gating mismatch");

   // the raw status tracks the last sampled levels
   raw_follows_levels: assert property (@(posedge clock) disable iff (reset)
      raw_lines_ff == prev_levels_ff)
      else $error("raw line status diverged from sampled levels");

   // reads change no state
   read_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (take && (req_word.mode == mid_pkg::MODE_READ))
         |=> ($stable(line_enable_ff) && $stable(raw_lines_ff)))
      else $error("read mode changed state");

endmodule

// ===== rtl/mid_out_stage.sv =====
// ----------------------------------------------------------------------------
// mid_out_stage
// Result register: holds one result word while the consumer stalls.
// ----------------------------------------------------------------------------
module mid_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  mid_pkg::rsp_type rsp_in_word,
   output logic             out_ready,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mid_pkg::rsp_type rsp_word
);

   logic             valid_ff;
   logic             valid_in;
   mid_pkg::rsp_type word_ff;

   assign out_ready = ~valid_ff | ~rsp_stall;
   assign valid_in  = take | (valid_ff & rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= rsp_in_word;
      end
   end

endmodule

// ===== rtl/multicore_interrupt_distributor.sv =====
// A word accepted into the input register moves through the core logic into the result register and is shown on rsp_.
// Throughput: one word per cycle while rsp_stall is low; the state update and result logic are combinational
// between the input register and the result register.
// Reset (synchronous, active high) clears the route map, line levels, raw, enable,
// per-CPU active and software-pending status, and empties both registers.
// ----------------------------------------------------------------------------
// multicore_interrupt_distributor
// Routes interrupt line edges to CPU requests and handles software interrupts.
// ----------------------------------------------------------------------------
module multicore_interrupt_distributor #(
   parameter int NUM_LINES  = 8,
   parameter int NUM_CPUS   = 4,
   parameter int SOFT_WIDTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_line_levels,
   input  logic [7:0]  req_enable_value,
   input  logic [3:0]  req_target_cpus,
   input  logic [1:0]  req_cpu_index,
   input  logic [7:0]  req_soft_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_raise_req,
   output logic [3:0]  rsp_lower_req,
   output logic [3:0]  rsp_wake_cpus,
   output logic [7:0]  rsp_masked_status,
   output logic [7:0]  rsp_enable_now,
   output logic [7:0]  rsp_soft_pending
);

   logic [31:0]      route_map_ff;
   logic             take;
   logic             out_ready;
   mid_pkg::req_type req_word;
   mid_pkg::req_type held_word;
   mid_pkg::rsp_type core_word;
   mid_pkg::rsp_type rsp_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         route_map_ff <= '0;
      end else if (csr_write_en) begin
         route_map_ff <= csr_write_data;
      end
   end

   always_comb begin
      req_word.mode         = req_mode;
      req_word.line_levels  = req_line_levels;
      req_word.enable_value = req_enable_value;
      req_word.target_cpus  = req_target_cpus;
      req_word.cpu_index    = req_cpu_index;
      req_word.soft_bits    = req_soft_bits;
   end

   mid_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .out_ready (out_ready),
      .take      (take),
      .held_word (held_word)
   );

   mid_core #(
      .NUM_LINES  (NUM_LINES),
      .NUM_CPUS   (NUM_CPUS),
      .SOFT_WIDTH (SOFT_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .route_map (route_map_ff),
      .take      (take),
      .req_word  (held_word),
      .rsp_word  (core_word)
   );

   mid_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .rsp_in_word (core_word),
      .out_ready   (out_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word)
   );

   assign rsp_raise_req     = rsp_word.raise_req;
   assign rsp_lower_req     = rsp_word.lower_req;
   assign rsp_wake_cpus     = rsp_word.wake_cpus;
   assign rsp_masked_status = rsp_word.masked_status;
   assign rsp_enable_now    = rsp_word.enable_now;
   assign rsp_soft_pending  = rsp_word.soft_pending;

   // a CPU is never raised and lowered by the same word
   no_raise_and_lower: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_raise_req & rsp_lower_req) == 4'b0))
      else $error("raise and lower on one CPU");

   // wakeups only come with a raise
   wake_needs_raise: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_wake_cpus & ~rsp_raise_req) == 4'b0))
      else $error("wakeup without raise");

   // a word moved out of the input register shows up as a result
   take_gives_result: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid)
      else $error("result lost after take");

   // masked status is always a subset of the enable mask
   masked_in_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_masked_status & ~rsp_enable_now) == 8'b0))
      else $error("masked status outside enable mask");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the multicore interrupt distributor against a cycle-free predictor
// of its line, enable and software interrupt state. A directed pass walks
// the edge, enable, post and acknowledge corner cases, then random traffic
// runs under several route maps with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

   localparam int NCPU  = 4;
   localparam int NLINE = 8;
   localparam logic [2:0] MODE_LAST = 3'd7;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [31:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_mode = mid_pkg::MODE_READ;
   logic [7:0]  req_line_levels = '0;
   logic [7:0]  req_enable_value = '0;
   logic [3:0]  req_target_cpus = '0;
   logic [1:0]  req_cpu_index = '0;
   logic [7:0]  req_soft_bits = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_raise_req;
   logic [3:0]  rsp_lower_req;
   logic [3:0]  rsp_wake_cpus;
   logic [7:0]  rsp_masked_status;
   logic [7:0]  rsp_enable_now;
   logic [7:0]  rsp_soft_pending;

   // predictor state
   logic [31:0] route_map = '0;
   logic [7:0]  line_prev = '0;
   logic [7:0]  line_raw = '0;
   logic [7:0]  line_en = '0;
   logic [7:0]  cpu_raw [NCPU] = '{default: '0};
   logic [7:0]  cpu_active [NCPU] = '{default: '0};
   logic [7:0]  cpu_soft [NCPU] = '{default: '0};

   mid_pkg::rsp_type expected_q [$];
   int          err_count = 0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   logic [7:0]  gen_levels = '0;

   multicore_interrupt_distributor u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_line_levels   (req_line_levels),
      .req_enable_value  (req_enable_value),
      .req_target_cpus   (req_target_cpus),
      .req_cpu_index     (req_cpu_index),
      .req_soft_bits     (req_soft_bits),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_raise_req     (rsp_raise_req),
      .rsp_lower_req     (rsp_lower_req),
      .rsp_wake_cpus     (rsp_wake_cpus),
      .rsp_masked_status (rsp_masked_status),
      .rsp_enable_now    (rsp_enable_now),
      .rsp_soft_pending  (rsp_soft_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one word to the distributor state and returns the request
   // changes and status it should report.
   function automatic mid_pkg::rsp_type predict_irq(mid_pkg::req_type w);
      mid_pkg::rsp_type r;
      logic [7:0] rise;
      logic [7:0] fall;
      logic [7:0] hit;
      logic [3:0] up;
      logic [3:0] down;
      r    = '0;
      up   = '0;
      down = '0;
      case (w.mode)
         mid_pkg::MODE_SAMPLE: begin
            rise = w.line_levels & ~line_prev;
            fall = line_prev & ~w.line_levels;
            // edges are taken from line 0 upward
            for (int i = 0; i < NLINE; i++) begin
               if (rise[i]) begin
                  line_raw[i] = 1'b1;
                  for (int c = 0; c < NCPU; c++) begin
                     if (route_map[i*NCPU+c]) begin
                        cpu_raw[c][i] = 1'b1;
                        if (line_en[i]) begin
                           if (cpu_active[c] == '0) up[c] = 1'b1;
                           cpu_active[c][i] = 1'b1;
                        end
                     end
                  end
               end else if (fall[i]) begin
                  line_raw[i] = 1'b0;
                  for (int c = 0; c < NCPU; c++) begin
                     if (route_map[i*NCPU+c]) begin
                        cpu_raw[c][i] = 1'b0;
                        if (line_en[i]) begin
                           cpu_active[c][i] = 1'b0;
                           if (cpu_active[c] == '0) down[c] = 1'b1;
                        end
                     end
                  end
               end
            end
            for (int c = 0; c < NCPU; c++) begin
               if (cpu_soft[c] == '0) begin
                  if (up[c]) begin
                     r.raise_req[c] = 1'b1;
                     r.wake_cpus[c] = 1'b1;
                  end else if (down[c]) begin
                     r.lower_req[c] = 1'b1;
                  end
               end
            end
            line_prev = w.line_levels;
         end
         mid_pkg::MODE_ENABLE: begin
            for (int c = 0; c < NCPU; c++) begin
               hit = cpu_raw[c] & w.enable_value;
               if (cpu_soft[c] == '0) begin
                  if (cpu_active[c] == '0 && hit != '0) r.raise_req[c] = 1'b1;
                  else if (cpu_active[c] != '0 && hit == '0) r.lower_req[c] = 1'b1;
               end
               cpu_active[c] = hit;
            end
            line_en = w.enable_value;
         end
         mid_pkg::MODE_POST: begin
            for (int c = 0; c < NCPU; c++) begin
               if (w.target_cpus[c]) begin
                  cpu_soft[c] = cpu_soft[c] | w.soft_bits;
                  if (cpu_active[c] == '0) begin
                     r.raise_req[c] = 1'b1;
                     r.wake_cpus[c] = 1'b1;
                  end
               end
            end
         end
         mid_pkg::MODE_ACK: begin
            if (cpu_soft[w.cpu_index] != '0) begin
               cpu_soft[w.cpu_index] = cpu_soft[w.cpu_index] & ~w.soft_bits;
               if (cpu_active[w.cpu_index] == '0 && cpu_soft[w.cpu_index] == '0)
                  r.lower_req[w.cpu_index] = 1'b1;
            end
         end
         default: ;  // read and spare modes leave the state alone
      endcase
      r.masked_status = line_raw & line_en;
      r.enable_now    = line_en;
      r.soft_pending  = cpu_soft[w.cpu_index];
      return r;
   endfunction

   // request side: predict each accepted word
   always @(posedge clock) begin : req_monitor
      mid_pkg::req_type w;
      if (!reset && req_valid && !req_stall) begin
         w = {req_mode, req_line_levels, req_enable_value, req_target_cpus,
              req_cpu_index, req_soft_bits};
         expected_q = {expected_q, predict_irq(w)};
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
         err_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_checker
      mid_pkg::rsp_type exp_word;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $error("result word with no expected word pending");
            err_count++;
         end else begin
            exp_word = expected_q.pop_front();
            check_field("raise_req", 8'(exp_word.raise_req), 8'(rsp_raise_req));
            check_field("lower_req", 8'(exp_word.lower_req), 8'(rsp_lower_req));
            check_field("wake_cpus", 8'(exp_word.wake_cpus), 8'(rsp_wake_cpus));
            check_field("masked_status", exp_word.masked_status, rsp_masked_status);
            check_field("enable_now", exp_word.enable_now, rsp_enable_now);
            check_field("soft_pending", exp_word.soft_pending, rsp_soft_pending);
         end
      end
   end

   // Called at a rising edge; returns at the edge where the word is taken.
   // Valid stays high so a following word goes out back to back.
   task automatic send_word(logic [2:0] mode, logic [7:0] levels, logic [7:0] enables,
                            logic [3:0] targets, logic [1:0] cpu, logic [7:0] swi_bits);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_line_levels  <= levels;
      req_enable_value <= enables;
      req_target_cpus  <= targets;
      req_cpu_index    <= cpu;
      req_soft_bits    <= swi_bits;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_q.size() != 0);
   endtask

   task automatic write_route_map(logic [31:0] value);
      wait_drained();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      route_map = value;
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_word(mid_pkg::MODE_READ, 8'h00, 8'h00, 4'h0, 2'd0, 8'h00);
      write_route_map(32'hFFFF_FFFF);
      // raw only, nothing enabled
      send_word(mid_pkg::MODE_SAMPLE, 8'hFF, 8'h00, 4'h0, 2'd0, 8'h00);
      // enable raises all
      send_word(mid_pkg::MODE_ENABLE, 8'h00, 8'hFF, 4'h0, 2'd1, 8'h00);
      // all fall, lower all
      send_word(mid_pkg::MODE_SAMPLE, 8'h00, 8'h00, 4'h0, 2'd2, 8'h00);
      send_word(mid_pkg::MODE_SAMPLE, 8'h0F, 8'h00, 4'h0, 2'd3, 8'h00);
      // falls empty the set before the rises refill it: raise wins
      send_word(mid_pkg::MODE_SAMPLE, 8'hF0, 8'h00, 4'h0, 2'd0, 8'h00);
      send_word(mid_pkg::MODE_SAMPLE, 8'h0F, 8'h00, 4'h0, 2'd0, 8'h00);
      send_word(mid_pkg::MODE_POST, 8'h00, 8'h00, 4'hF, 2'd0, 8'h00);
      // disable lowers all
      send_word(mid_pkg::MODE_ENABLE, 8'h00, 8'h00, 4'h0, 2'd0, 8'h00);
      // zero soft still raises
      send_word(mid_pkg::MODE_POST, 8'h00, 8'h00, 4'h5, 2'd2, 8'h00);
      // no targets
      send_word(mid_pkg::MODE_POST, 8'hFF, 8'hFF, 4'h0, 2'd1, 8'hFF);
      send_word(mid_pkg::MODE_POST, 8'h00, 8'h00, 4'hF, 2'd3, 8'hFF);
      send_word(mid_pkg::MODE_ACK, 8'h00, 8'h00, 4'h0, 2'd3, 8'h0F);
      // soft pending, no raise
      send_word(mid_pkg::MODE_ENABLE, 8'h00, 8'hFF, 4'h0, 2'd3, 8'h00);
      // soft pending, no lower
      send_word(mid_pkg::MODE_SAMPLE, 8'h00, 8'h00, 4'h0, 2'd3, 8'h00);
      send_word(mid_pkg::MODE_ACK, 8'h00, 8'h00, 4'h0, 2'd3, 8'hFF);
      // nothing pending
      send_word(mid_pkg::MODE_ACK, 8'h00, 8'h00, 4'h0, 2'd3, 8'hFF);
      send_word(mid_pkg::MODE_ACK, 8'h00, 8'h00, 4'h0, 2'd0, 8'h00);
      for (logic [2:0] m = mid_pkg::MODE_READ + 3'd1; m != mid_pkg::MODE_READ; m++)
         send_word(m, 8'(~m), 8'hFF, 4'hF, 2'(m), 8'hFF);
      send_word(mid_pkg::MODE_ACK, 8'hFF, 8'hFF, 4'hF, 2'd1, 8'hFF);
      send_word(mid_pkg::MODE_ACK, 8'h00, 8'h00, 4'h0, 2'd2, 8'hFF);
      send_word(mid_pkg::MODE_ACK, 8'h00, 8'h00, 4'h0, 2'd0, 8'hFF);
      send_word(mid_pkg::MODE_SAMPLE, 8'hAA, 8'h00, 4'h0, 2'd1, 8'h00);
      send_word(mid_pkg::MODE_SAMPLE, 8'h55, 8'h00, 4'h0, 2'd2, 8'h00);
      gen_levels = 8'h55;
   endtask

   task automatic random_word();
      int         pick;
      logic [2:0] mode;
      logic [7:0] levels;
      logic [7:0] enables;
      logic [7:0] swi_bits;
      pick = $urandom_range(99);
      if (pick < 40) mode = mid_pkg::MODE_SAMPLE;
      else if (pick < 55) mode = mid_pkg::MODE_ENABLE;
      else if (pick < 70) mode = mid_pkg::MODE_POST;
      else if (pick < 88) mode = mid_pkg::MODE_ACK;
      else if (pick < 96) mode = mid_pkg::MODE_READ;
      else mode = 3'($urandom_range(MODE_LAST, mid_pkg::MODE_READ + 3'd1));
      // mostly single or double line toggles so the active sets fill and drain
      if ($urandom_range(3) == 0) levels = 8'($urandom);
      else levels = gen_levels ^ (8'd1 << $urandom_range(NLINE - 1))
                                ^ (($urandom_range(1) == 1) ? 8'd0 : 8'd1 << $urandom_range(7));
      enables = ($urandom_range(4) == 0) ? 8'hFF : 8'($urandom);
      swi_bits = 8'($urandom);
      if (mode == mid_pkg::MODE_POST && $urandom_range(6) == 0) swi_bits = 8'h00;
      if (mode == mid_pkg::MODE_ACK && $urandom_range(9) < 4) swi_bits = 8'hFF;
      if (mode == mid_pkg::MODE_SAMPLE) gen_levels = levels;
      send_word(mode, levels, enables, 4'($urandom), 2'($urandom), swi_bits);
   endtask

   task automatic test_unrouted();
      write_route_map(32'h0000_0000);
      repeat (15) random_word();
   endtask

   task automatic test_random_traffic(int idle_pct, int stall_pct, logic [31:0] routes);
      write_route_map(routes);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int n = 0; n < 105; n++) begin
         if ($urandom_range(49) == 0) wait_drained();
         random_word();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_unrouted();
      test_random_traffic(0, 0, $urandom);
      test_random_traffic(83, 0, 32'h8421_1248);
      test_random_traffic(0, 83, $urandom);
      test_random_traffic(34, 34, 32'hFFFF_FFFF);
      wait_drained();
      repeat (4) @(posedge clock);
      if (err_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
